>>> src/vnfbm_pkg.sv
// ----------------------------------------------------------------------------
// vnfbm_pkg
// Shared constants for the fractal value noise pipeline: hash multipliers,
// octave salt, widths, register indices, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package vnfbm_pkg;

    localparam int unsigned MAX_OCTAVES_DEF = 8;
    localparam int unsigned FRAC_BITS_DEF   = 16;

    localparam logic [31:0] HASH_MUL_X   = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Z   = 32'hd8163841;
    localparam logic [31:0] HASH_MUL_MIX = 32'h2545f491;
    localparam logic [31:0] OCTAVE_SALT  = 32'd101;

    localparam int unsigned Q24_W    = 24;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned OCT_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 8'd1;

    localparam logic [31:0]          SEED_RESET   = 32'd0;
    localparam logic [OCT_CNT_W-1:0] OCTAVE_RESET = 4'd4;

endpackage

>>> src/value_noise_fbm.sv
// ----------------------------------------------------------------------------
// value_noise_fbm
// 2-D fractal value noise: per-octave lattice hash, smoothstep bilinear blend,
// weighted octave sum and normalization by a reciprocal of (2^n - 1).
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[31:0] pos_x, tdata[63:32] pos_z
//  m_axis    | out       | tdata[23:0] noise_value
//  cfg       | in        | cfg_index 0 noise_seed, 1 octave_count; cfg_data
//
//  an accepted item is registered through every stage to its result; one item per cycle
//  sustained while the sink takes results, all octaves run side by side in their own lanes
//  multipliers sit in the hash, smoothstep, lerp and reciprocal stages
//  each stage holds while its successor is full and stalled, so bubbles fill up
//  aresetn clears valid bits and config registers; payload registers are not reset
//  cfg writes are always taken and are meant only while the pipeline is empty
// ----------------------------------------------------------------------------
module value_noise_fbm #(
    parameter int unsigned MAX_OCTAVES = vnfbm_pkg::MAX_OCTAVES_DEF,
    parameter int unsigned FRAC_BITS   = vnfbm_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*vnfbm_pkg::POS_W-1:0]    s_tdata,   // pos_x, pos_z
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vnfbm_pkg::Q24_W-1:0]      m_tdata,   // noise_value
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vnfbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vnfbm_pkg::CFG_DAT_W-1:0]  cfg_data
);

    localparam int NST   = 9;
    localparam int NW    = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W = vnfbm_pkg::Q24_W + MAX_OCTAVES;
    localparam int SH    = ACC_W + 1;
    localparam int PW    = ACC_W + SH;
    localparam int QW    = vnfbm_pkg::Q24_W + 1;
    localparam logic [24:0] ONE_Q24 = 25'h1000000;

    // floor(2^SH / (2^n - 1)) less at most one, as a geometric series
    function automatic logic [MAX_OCTAVES*SH-1:0] recip_table();
        logic [MAX_OCTAVES*SH-1:0] tab;
        logic [63:0]               r;
        tab = '0;
        for (int n = 1; n <= MAX_OCTAVES; n++) begin
            r = '0;
            for (int k = 1; k <= SH; k++) begin
                if (k * n <= SH) begin
                    r = r + (64'd1 << (SH - k * n));
                end
            end
            tab[(n-1)*SH +: SH] = r[SH-1:0];
        end
        return tab;
    endfunction

    localparam logic [MAX_OCTAVES*SH-1:0] RECIP = recip_table();

    logic [31:0]                     noise_seed_reg;
    logic [vnfbm_pkg::OCT_CNT_W-1:0] octave_count_reg;
    logic [NW-1:0]                   n_eff;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   en;

    logic signed [31:0] x_reg, z_reg;
    logic [31:0] mx_reg  [MAX_OCTAVES];
    logic [31:0] mz_reg  [MAX_OCTAVES];
    logic [47:0] ttx_reg [MAX_OCTAVES];
    logic [47:0] ttz_reg [MAX_OCTAVES];
    logic [23:0] tx_reg  [MAX_OCTAVES];
    logic [23:0] tz_reg  [MAX_OCTAVES];
    logic [31:0] hs_reg  [MAX_OCTAVES][4];
    logic [31:0] hm_reg  [MAX_OCTAVES][4];
    logic [24:0] u2_reg  [MAX_OCTAVES];
    logic [24:0] v2_reg  [MAX_OCTAVES];
    logic [24:0] u3_reg  [MAX_OCTAVES];
    logic [24:0] v3_reg  [MAX_OCTAVES];
    logic [24:0] v4_reg  [MAX_OCTAVES];
    logic [23:0] ab_reg  [MAX_OCTAVES];
    logic [23:0] cd_reg  [MAX_OCTAVES];
    logic [23:0] oct_reg [MAX_OCTAVES];

    logic [ACC_W-1:0] acc_next, acc_reg, acc2_reg;
    logic [PW-1:0]    prod_reg;
    logic [SH-1:0]    recip;
    logic [QW-1:0]    q_est;
    logic [ACC_W:0]   q_back, rem, divisor;
    logic [QW-1:0]    q_fix;
    logic [23:0]      out_next, out_reg;

    // config registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg   <= vnfbm_pkg::SEED_RESET;
            octave_count_reg <= vnfbm_pkg::OCTAVE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                vnfbm_pkg::REG_NOISE_SEED:   noise_seed_reg   <= cfg_data;
                vnfbm_pkg::REG_OCTAVE_COUNT:
                    octave_count_reg <= cfg_data[vnfbm_pkg::OCT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (octave_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (int'(octave_count_reg) > int'(MAX_OCTAVES)) begin
            n_eff = NW'(MAX_OCTAVES);
        end else begin
            n_eff = NW'(octave_count_reg);
        end
    end

    // per-stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg <= s_tdata[31:0];
            z_reg <= s_tdata[63:32];
        end
    end

    for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_lane
        logic [63:0] sx, sz;
        logic [31:0] cx, cz;
        logic [23:0] fx, fz;
        logic [31:0] seed_i, base;
        logic [31:0] h0 [4];
        logic [25:0] kx, kz;
        logic [49:0] wx, wz;
        logic [31:0] hv [4];
        logic [49:0] lab, lcd, lo;

        assign sx = 64'(x_reg) << gi;
        assign sz = 64'(z_reg) << gi;
        assign cx = sx[FRAC_BITS +: 32];
        assign cz = sz[FRAC_BITS +: 32];
        assign fx = 24'(sx[FRAC_BITS-1:0]) << (24 - FRAC_BITS);
        assign fz = 24'(sz[FRAC_BITS-1:0]) << (24 - FRAC_BITS);

        // neighbor corners differ in the product by the hash multiplier itself
        assign seed_i = noise_seed_reg + 32'(32'(gi) * vnfbm_pkg::OCTAVE_SALT);
        assign base   = mx_reg[gi] + mz_reg[gi] + seed_i;
        assign h0[0]  = base;
        assign h0[1]  = base + vnfbm_pkg::HASH_MUL_X;
        assign h0[2]  = base + vnfbm_pkg::HASH_MUL_Z;
        assign h0[3]  = base + vnfbm_pkg::HASH_MUL_X + vnfbm_pkg::HASH_MUL_Z;

        assign kx = 26'h3000000 - {1'b0, tx_reg[gi], 1'b0};
        assign kz = 26'h3000000 - {1'b0, tz_reg[gi], 1'b0};
        assign wx = 50'(ttx_reg[gi][47:24]) * 50'(kx);
        assign wz = 50'(ttz_reg[gi][47:24]) * 50'(kz);

        for (genvar c = 0; c < 4; c++) begin : g_corner
            assign hv[c] = hm_reg[gi][c] ^ (hm_reg[gi][c] >> 15);
        end

        assign lab = 50'(hv[0][23:0]) * 50'(ONE_Q24 - u3_reg[gi])
                   + 50'(hv[1][23:0]) * 50'(u3_reg[gi]);
        assign lcd = 50'(hv[2][23:0]) * 50'(ONE_Q24 - u3_reg[gi])
                   + 50'(hv[3][23:0]) * 50'(u3_reg[gi]);
        assign lo  = 50'(ab_reg[gi]) * 50'(ONE_Q24 - v4_reg[gi])
                   + 50'(cd_reg[gi]) * 50'(v4_reg[gi]);

        always_ff @(posedge aclk) begin
            if (en[1]) begin
                mx_reg[gi]  <= 32'(cx * vnfbm_pkg::HASH_MUL_X);
                mz_reg[gi]  <= 32'(cz * vnfbm_pkg::HASH_MUL_Z);
                ttx_reg[gi] <= 48'(fx) * 48'(fx);
                ttz_reg[gi] <= 48'(fz) * 48'(fz);
                tx_reg[gi]  <= fx;
                tz_reg[gi]  <= fz;
            end
            if (en[2]) begin
                for (int c = 0; c < 4; c++) begin
                    hs_reg[gi][c] <= h0[c] ^ (h0[c] >> 13);
                end
                u2_reg[gi] <= wx[48:24];
                v2_reg[gi] <= wz[48:24];
            end
            if (en[3]) begin
                for (int c = 0; c < 4; c++) begin
                    hm_reg[gi][c] <= 32'(hs_reg[gi][c] * vnfbm_pkg::HASH_MUL_MIX);
                end
                u3_reg[gi] <= u2_reg[gi];
                v3_reg[gi] <= v2_reg[gi];
            end
            if (en[4]) begin
                ab_reg[gi] <= lab[47:24];
                cd_reg[gi] <= lcd[47:24];
                v4_reg[gi] <= v3_reg[gi];
            end
            if (en[5]) begin
                oct_reg[gi] <= lo[47:24];
            end
        end
    end

    // octave i weighs 2^(n-1-i)
    always_comb begin
        acc_next = '0;
        for (int i = 0; i < MAX_OCTAVES; i++) begin
            if (i < int'(n_eff)) begin
                acc_next = acc_next + (ACC_W'(oct_reg[i]) << (int'(n_eff) - 1 - i));
            end
        end
    end

    assign recip   = RECIP[(int'(n_eff) - 1) * SH +: SH];
    assign divisor = (ACC_W+1)'((ACC_W+1)'(1) << n_eff) - (ACC_W+1)'(1);
    assign q_est   = QW'(prod_reg >> SH);
    assign q_back  = ((ACC_W+1)'(q_est) << n_eff) - (ACC_W+1)'(q_est);
    assign rem     = (ACC_W+1)'(acc2_reg) - q_back;

    // estimate is exact or one low
    always_comb begin
        q_fix = (rem >= divisor) ? q_est + QW'(1) : q_est;
        out_next = q_fix[QW-1] ? 24'hFFFFFF : q_fix[23:0];
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            acc_reg <= acc_next;
        end
        if (en[7]) begin
            prod_reg <= PW'(acc_reg) * PW'(recip);
            acc2_reg <= acc_reg;
        end
        if (en[8]) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/vnfbm_checker.sv
// ----------------------------------------------------------------------------
// vnfbm_checker
// Port-level checks on the fractal value noise block, bound to its top level.
// ----------------------------------------------------------------------------
module vnfbm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [vnfbm_pkg::Q24_W-1:0] m_tdata,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty output stage means every stage can take an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_cfg_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind value_noise_fbm vnfbm_checker u_vnfbm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> bench/tb_value_noise_fbm.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_value_noise_fbm
// Streams 2-D points through the fractal value noise block under random
// idling on both sides, predicts each noise value with an independent
// fixed-point model and checks results in order, across seed and octave
// count settings including the extremes and out-of-range writes.
// ----------------------------------------------------------------------------
module tb_value_noise_fbm;

    localparam int FRAC = vnfbm_pkg::FRAC_BITS_DEF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [vnfbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vnfbm_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    logic [31:0] cur_seed = vnfbm_pkg::SEED_RESET;
    logic [3:0]  cur_octaves = vnfbm_pkg::OCTAVE_RESET;
    logic [23:0] noise_queue[$];
    int          fail_count = 0;
    bit          stall_enable = 1'b1;
    int          stall_left = 0;

    always #6 aclk = ~aclk;

    value_noise_fbm DUT (.*);

    function automatic logic [23:0] corner_hash(logic [31:0] ix, logic [31:0] iz,
                                                logic [31:0] sd);
        logic [31:0] h;
        h = sd + ix * vnfbm_pkg::HASH_MUL_X + iz * vnfbm_pkg::HASH_MUL_Z;
        h = h ^ (h >> 13);
        h = h * vnfbm_pkg::HASH_MUL_MIX;
        h = h ^ (h >> 15);
        return h[23:0];
    endfunction

    function automatic logic [63:0] fade(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> 24;
        return (t2 * (64'd3 * 64'd16777216 - 64'd2 * t)) >> 24;
    endfunction

    function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd16777216 - w) + b * w) >> 24;
    endfunction

    function automatic logic [23:0] predict_noise(logic [31:0] px, logic [31:0] pz);
        int unsigned n;
        logic [63:0] acc, sx, sz, fx, fz, u, v, ab, cd;
        logic [31:0] x0, z0, sd;
        n = (cur_octaves == 0) ? 1
            : (cur_octaves > vnfbm_pkg::MAX_OCTAVES_DEF) ? vnfbm_pkg::MAX_OCTAVES_DEF
            : cur_octaves;
        acc = 0;
        for (int i = 0; i < n; i++) begin
            sd = cur_seed + i * vnfbm_pkg::OCTAVE_SALT;
            sx = {{32{px[31]}}, px} << i;
            sz = {{32{pz[31]}}, pz} << i;
            x0 = sx[FRAC+31:FRAC];
            z0 = sz[FRAC+31:FRAC];
            fx = (sx & ((64'd1 << FRAC) - 1)) << (24 - FRAC);
            fz = (sz & ((64'd1 << FRAC) - 1)) << (24 - FRAC);
            u = fade(fx);
            v = fade(fz);
            ab = blend(corner_hash(x0, z0, sd), corner_hash(x0 + 1, z0, sd), u);
            cd = blend(corner_hash(x0, z0 + 1, sd), corner_hash(x0 + 1, z0 + 1, sd), u);
            acc += blend(ab, cd, v) << (n - 1 - i);
        end
        acc = acc / ((64'd1 << n) - 1);
        return (acc > 64'hFFFFFF) ? 24'hFFFFFF : acc[23:0];
    endfunction

    task automatic send_point(logic [31:0] px, logic [31:0] pz);
        int gap;
        gap = stall_enable ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, px};
        noise_queue = {noise_queue, predict_noise(px, pz)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (noise_queue.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [vnfbm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == vnfbm_pkg::REG_NOISE_SEED) cur_seed = val;
        else if (idx == vnfbm_pkg::REG_OCTAVE_COUNT) cur_octaves = val[3:0];
    endtask

    // result checker; each taken item draws the sink's idle cycles
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            stall_left = stall_enable ? $urandom_range(0, 6) : 0;
            if (noise_queue.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                if (m_tdata !== noise_queue[0]) begin
                    $display("%0t: noise_value mismatch, expected %h, actual %h",
                             $time, noise_queue[0], m_tdata);
                    fail_count++;
                end
                void'(noise_queue.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [31:0] edges[6] = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                  32'h0000FFFF, 32'h00010000};
        foreach (edges[i]) send_point(edges[i], edges[5 - i]);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'hFFFF8000, 32'h00008000);
        drain();
    endtask

    task automatic test_octave_limits();
        logic [3:0] counts[5] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
        foreach (counts[k]) begin
            write_reg(vnfbm_pkg::REG_OCTAVE_COUNT,
                      {$urandom_range(0, 1) ? 28'hFFFFFFF : 28'h0, counts[k]});
            send_point(32'h7FFFFFFF, 32'h80000000);
            send_point(32'hFFFFFFFF, 32'h0001_8000);
            send_point($urandom, $urandom);
            drain();
        end
    endtask

    task automatic test_ignored_index();
        write_reg(vnfbm_pkg::REG_NOISE_SEED, 32'hFFFFFFFF);
        write_reg(8'd2, 32'h12345678);
        write_reg(8'hFF, 32'hFFFFFFFF);
        send_point(32'h00012345, 32'hFFFE0001);
        send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();
    endtask

    task automatic test_random_points(int count);
        logic [31:0] px, pz;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin px = $urandom; pz = $urandom; end
                // near the lattice wrap
                1: begin
                    px = {$urandom_range(0, 1) ? 8'h7F : 8'h80, 24'($urandom)};
                    pz = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
                end
                default: begin
                    px = $signed(16'($urandom)) * 32'sd16 + 32'($urandom_range(0, 65535));
                    pz = $signed(16'($urandom)) * 32'sd16 + 32'($urandom_range(0, 65535));
                end
            endcase
            send_point(px, pz);
        end
        drain();
    endtask

    task automatic test_settings_sweep();
        for (int p = 0; p < 6; p++) begin
            write_reg(vnfbm_pkg::REG_NOISE_SEED, (p == 0) ? 32'h0 : $urandom);
            write_reg(vnfbm_pkg::REG_OCTAVE_COUNT, $urandom_range(1, 8));
            stall_enable = (p != 2);
            test_random_points(240);
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_octave_limits();
        test_ignored_index();
        test_settings_sweep();
        if (fail_count == 0 && noise_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
src/vnfbm_pkg.sv
src/value_noise_fbm.sv
src/vnfbm_checker.sv
bench/tb_value_noise_fbm.sv
